// File: rtl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  // Phases of the escape decoder.
  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_HEX    = 3'd2;

  // Characters that matter to the decoder.
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_V     = 8'h76;

  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_TAB  = 8'h09;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_VT   = 8'h0B;

  // Most bytes one input can cause: backslash, letter, three digits, offending byte.
  localparam int JOB_BYTES  = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  // Work for the back end: the bytes one input produced.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;  // 0 only for an end-of-string marker
    logic                      last;
  } jsu_job_t;

endpackage

// File: rtl/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       job_push,
  output jsu_job_t   job
);

  logic [2:0]       phase_r, phase_nxt;
  logic [2:0]       count_r, count_nxt;
  logic [15:0]      code_r, code_nxt;
  logic [7:0]       letter_r, letter_nxt;
  logic             stopped_r, stopped_nxt;
  logic [3:0][7:0]  held_r;
  logic             held_we;

  logic [JOB_BYTES-1:0][7:0] cand;
  logic [2:0]       ncand;
  logic [2:0]       n_eff;
  logic [2:0]       first_zero;
  logic             zero_found;
  logic [4:0]       hv;
  logic [2:0]       need;
  logic [2:0]       count_inc;

  // Bit 4 flags a character that is no hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  always_comb begin
    cand        = '0;
    ncand       = 3'd0;
    phase_nxt   = PH_NORMAL;
    count_nxt   = count_r;
    code_nxt    = code_r;
    letter_nxt  = letter_r;
    held_we     = 1'b0;
    hv          = hex_val(in_byte);
    need        = (letter_r == CH_X) ? 3'd2 : 3'd4;
    count_inc   = count_r + 3'd1;

    unique case (phase_r)
      PH_ESC: begin
        unique case (in_byte)
          CH_U, CH_X: begin
            letter_nxt = in_byte;
            count_nxt  = 3'd0;
            code_nxt   = '0;
            if (in_last) begin
              cand[0] = CH_BSL;
              cand[1] = in_byte;
              ncand   = 3'd2;
            end else begin
              phase_nxt = PH_HEX;
            end
          end
          CH_DIG0, CH_A: ;
          CH_B: begin cand[0] = CTL_BS;  ncand = 3'd1; end
          CH_F: begin cand[0] = CTL_FF;  ncand = 3'd1; end
          CH_T: begin cand[0] = CTL_TAB; ncand = 3'd1; end
          CH_R: begin cand[0] = CTL_CR;  ncand = 3'd1; end
          CH_N: begin cand[0] = CTL_LF;  ncand = 3'd1; end
          CH_V: begin cand[0] = CTL_VT;  ncand = 3'd1; end
          default: begin cand[0] = in_byte; ncand = 3'd1; end
        endcase
      end
      PH_HEX: begin
        // A replay lists backslash, letter, held digits, then this byte, which
        // is either the digit that just arrived or the offending byte.
        cand[0] = CH_BSL;
        cand[1] = letter_r;
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < count_r) cand[2+k] = held_r[k];
          else if (3'(k) == count_r) cand[2+k] = in_byte;
        end
        if (!hv[4] && count_r < 3'd4) begin
          held_we   = 1'b1;
          count_nxt = count_inc;
          code_nxt  = {code_r[11:0], hv[3:0]};
          if (count_inc >= need) begin
            cand = '0;
            if (letter_r == CH_X) begin
              cand[0] = code_nxt[7:0];
              ncand   = 3'd1;
            end else if (code_nxt < 16'h0080) begin
              cand[0] = code_nxt[7:0];
              ncand   = 3'd1;
            end else if (code_nxt < 16'h0800) begin
              cand[0] = {3'b110, code_nxt[10:6]};
              cand[1] = {2'b10, code_nxt[5:0]};
              ncand   = 3'd2;
            end else begin
              cand[0] = {4'b1110, code_nxt[15:12]};
              cand[1] = {2'b10, code_nxt[11:6]};
              cand[2] = {2'b10, code_nxt[5:0]};
              ncand   = 3'd3;
            end
          end else if (in_last) begin
            ncand = count_r + 3'd3;
          end else begin
            phase_nxt = PH_HEX;
          end
        end else if (in_byte == CH_BSL) begin
          ncand = count_r + 3'd2;
          if (!in_last) phase_nxt = PH_ESC;
        end else begin
          ncand = count_r + 3'd3;
        end
      end
      default: begin
        if (in_byte == CH_BSL) begin
          if (!in_last) phase_nxt = PH_ESC;
        end else begin
          cand[0] = in_byte;
          ncand   = 3'd1;
        end
      end
    endcase
  end

  // A decoded zero ends output for the rest of the string; only a suffix is lost.
  always_comb begin
    zero_found = 1'b0;
    first_zero = 3'd0;
    for (int k = 0; k < JOB_BYTES; k++) begin
      if (!zero_found && 3'(k) < ncand && cand[k] == 8'h00) begin
        zero_found = 1'b1;
        first_zero = 3'(k);
      end
    end
    if (stopped_r)       n_eff = 3'd0;
    else if (zero_found) n_eff = first_zero;
    else                 n_eff = ncand;
    stopped_nxt = stopped_r | zero_found;
  end

  assign job.bytes = cand;
  assign job.count = n_eff;
  assign job.last  = in_last;
  assign job_push  = in_fire && (n_eff != 3'd0 || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NORMAL;
      count_r   <= 3'd0;
      code_r    <= '0;
      letter_r  <= '0;
      stopped_r <= 1'b0;
    end else if (in_fire) begin
      if (in_last) begin
        phase_r   <= PH_NORMAL;
        count_r   <= 3'd0;
        code_r    <= '0;
        letter_r  <= '0;
        stopped_r <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        count_r   <= count_nxt;
        code_r    <= code_nxt;
        letter_r  <= letter_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && held_we) begin
      held_r[count_r[1:0]] <= in_byte;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jsu_job_t push_job,
  input  logic     pop,
  output jsu_job_t head,
  output logic     full,
  output logic     empty
);

  jsu_job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_r, rd_r;
  logic [QPTR_W:0]       cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_job;
  end

endmodule

// File: rtl/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  jsu_job_t   head,
  input  logic       empty,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, run_end_r, str_end_r;

  logic       load;
  logic [2:0] last_pos;
  logic       final_byte;
  logic [7:0] sel_byte;

  // The output register takes a new result whenever it is empty or being drained.
  assign load       = !empty && (!valid_r || out_tready);
  assign last_pos   = (head.count == 3'd0) ? 3'd0 : head.count - 3'd1;
  assign final_byte = (idx_r == last_pos);
  assign pop        = load && final_byte;
  assign sel_byte   = (head.count == 3'd0) ? 8'h00 : head.bytes[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= final_byte ? 3'd0 : idx_r + 3'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= sel_byte;
      bvalid_r  <= (head.count != 3'd0);
      run_end_r <= final_byte;
      str_end_r <= final_byte && head.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = {run_end_r, bvalid_r};
  assign out_tlast  = str_end_r;

endmodule

// File: rtl/json_string_unescape.sv
`timescale 1ns / 1ps

// Streaming unescaper for the body of a quoted string. Raw bytes enter one per
// request; decoded bytes leave one per request, with \uXXXX turned into UTF-8,
// \xHH into one byte and the usual letter escapes into control bytes. Output
// stops at the first decoded zero byte until the string ends, and the request
// with tlast closes every string (a request with byte_valid low carries the end
// when the final input decodes to nothing). An input byte is taken every cycle
// while the four-entry job queue has room; the back end delivers one result per
// cycle while the receiver is ready, so an input that decodes to k bytes (up to
// six, for a broken hex escape) takes k results and the queue absorbs such
// bursts. An accepted input passes through the job queue and then the output
// register before its first result appears.
module json_string_unescape import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [1:0] out_tuser,   // [0] byte_valid, [1] run_end
  output logic       out_tlast
);

  jsu_job_t job, head;
  logic     job_push, pop, full, empty, in_fire;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .job_push (job_push),
    .job      (job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sim/jsu_unescape_check.sv
`timescale 1ns / 1ps

module jsu_unescape_check import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [7:0] out_byte
  input  logic [1:0] out_tuser,   // [0] byte_valid, [1] run_end
  input  logic       out_tlast,
  output int         pending,
  output int         fails,
  output int         n_raw,
  output int         n_decoded,
  output int         n_strings
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       str_end;
  } dec_result_t;

  dec_result_t decoded_q[$];
  logic [7:0]  step_bytes[$];

  // Decoder state as seen from outside.
  logic [2:0]  phase;
  logic [2:0]  n_digits;
  logic [15:0] code;
  logic [7:0]  digits [4];
  logic [7:0]  letter;
  logic        stopped;

  function void clear_state();
    phase    = PH_NORMAL;
    n_digits = '0;
    code     = '0;
    letter   = '0;
    stopped  = 1'b0;
    for (int k = 0; k < 4; k++) digits[k] = '0;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // A decoded zero byte is swallowed and mutes the rest of the string.
  function void put(logic [7:0] b);
    if (stopped) return;
    if (b == 8'h00) begin
      stopped = 1'b1;
      return;
    end
    step_bytes.push_back(b);
  endfunction

  function void replay_escape();
    put(CH_BSL);
    put(letter);
    for (int k = 0; k < n_digits && k < 4; k++) put(digits[k]);
  endfunction

  function void plain_in(logic [7:0] b, logic last);
    if (b == CH_BSL) begin
      phase = last ? PH_NORMAL : PH_ESC;
    end else begin
      put(b);
      phase = PH_NORMAL;
    end
  endfunction

  function void letter_in(logic [7:0] b, logic last);
    phase = PH_NORMAL;
    case (b)
      CH_U, CH_X: begin
        letter   = b;
        n_digits = '0;
        code     = '0;
        if (last) replay_escape();
        else phase = PH_HEX;
      end
      CH_DIG0, CH_A: ;  // these escapes decode to nothing
      CH_B: put(CTL_BS);
      CH_F: put(CTL_FF);
      CH_T: put(CTL_TAB);
      CH_R: put(CTL_CR);
      CH_N: put(CTL_LF);
      CH_V: put(CTL_VT);
      default: put(b);
    endcase
  endfunction

  function void emit_code();
    if (letter == CH_X || code < 16'h0080) begin
      put(code[7:0]);
    end else if (code < 16'h0800) begin
      put({3'b110, code[10:6]});
      put({2'b10, code[5:0]});
    end else begin
      put({4'b1110, code[15:12]});
      put({2'b10, code[11:6]});
      put({2'b10, code[5:0]});
    end
  endfunction

  function void hex_in(logic [7:0] b, logic last);
    int v;
    int need;
    v    = hex_value(b);
    need = (letter == CH_X) ? 2 : 4;
    if (v >= 0 && n_digits < 4) begin
      digits[n_digits[1:0]] = b;
      n_digits = n_digits + 3'd1;
      code     = {code[11:0], v[3:0]};
      if (n_digits >= need) begin
        emit_code();
        phase = PH_NORMAL;
      end else if (last) begin
        replay_escape();
        phase = PH_NORMAL;
      end
    end else begin
      // The broken sequence goes out literally and the bad byte starts afresh.
      replay_escape();
      phase = PH_NORMAL;
      plain_in(b, last);
    end
  endfunction

  function void decode_raw_byte(logic [7:0] b, logic last);
    dec_result_t r;
    step_bytes.delete();
    if (phase == PH_ESC) letter_in(b, last);
    else if (phase == PH_HEX) hex_in(b, last);
    else plain_in(b, last);
    foreach (step_bytes[k]) begin
      r.data    = step_bytes[k];
      r.valid   = 1'b1;
      r.run_end = (k == step_bytes.size() - 1);
      r.str_end = (k == step_bytes.size() - 1) && last;
      decoded_q.push_back(r);
    end
    if (step_bytes.size() == 0 && last) begin
      r = '{data: 8'h00, valid: 1'b0, run_end: 1'b1, str_end: 1'b1};
      decoded_q.push_back(r);
    end
    if (last) clear_state();
  endfunction

  function void report(string field, logic [7:0] want, logic [7:0] got);
    fails++;
    if (fails <= 40) $error("%s: expected %02h, got %02h", field, want, got);
  endfunction

  function void check_result();
    dec_result_t want;
    n_decoded++;
    if (decoded_q.size() == 0) begin
      fails++;
      if (fails <= 40) $error("unexpected result: out_byte %02h", out_tdata);
      return;
    end
    want = decoded_q.pop_front();
    if (out_tdata !== want.data) report("out_byte", want.data, out_tdata);
    if (out_tuser[0] !== want.valid)
      report("byte_valid", 8'(want.valid), 8'(out_tuser[0]));
    if (out_tuser[1] !== want.run_end)
      report("run_end", 8'(want.run_end), 8'(out_tuser[1]));
    if (out_tlast !== want.str_end)
      report("string_end", 8'(want.str_end), 8'(out_tlast));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_q.delete();
      fails     = 0;
      n_raw     = 0;
      n_decoded = 0;
      n_strings = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_raw_byte(in_tdata, in_tlast);
        n_raw++;
        if (in_tlast) n_strings++;
      end
      if (out_tvalid && out_tready) check_result();
    end
    pending <= decoded_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import jsu_pkg::*; ();

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 300;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] in_byte
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;            // [7:0] out_byte
  logic [1:0] out_tuser;            // [0] byte_valid, [1] run_end
  logic       out_tlast;

  int pending;
  int fails;
  int n_raw;
  int n_decoded;
  int n_strings;

  int cycles    = 0;
  int sent      = 0;
  int rx_taken  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  logic [7:0] text_q[$];

  always #6 clk = ~clk;

  json_string_unescape i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  jsu_unescape_check i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .pending    (pending),
    .fails      (fails),
    .n_raw      (n_raw),
    .n_decoded  (n_decoded),
    .n_strings  (n_strings)
  );

  // Receiver: random stalls, one long hold-off once the output is under way,
  // and a stretch of results taken back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_taken <= rx_taken + 1;
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_taken >= 60) begin
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (rx_taken >= 100 && rx_taken < 160) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return "0" + v;
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function void add_hex_escape(logic [7:0] kind, logic [15:0] val, int ndig);
    int total;
    total = (kind == CH_X) ? 2 : 4;
    text_q.push_back(CH_BSL);
    text_q.push_back(kind);
    for (int k = 0; k < ndig; k++) text_q.push_back(hex_char(val[4*(total-1-k) +: 4]));
  endfunction

  // Mostly well-formed escapes with random content; a few broken sequences.
  function void add_token(bit is_final);
    int         pick;
    logic [7:0] b;
    logic [7:0] kind;
    logic [15:0] val;
    pick = $urandom_range(99);
    if (pick < 40) begin
      do b = 8'($urandom_range(255)); while (b == CH_BSL);
      text_q.push_back(b);
    end else if (pick < 62) begin
      text_q.push_back(CH_BSL);
      case ($urandom_range(11))
        0: b = CH_B;
        1: b = CH_F;
        2: b = CH_T;
        3: b = CH_R;
        4: b = CH_N;
        5: b = CH_V;
        6: b = CH_A;
        7: b = CH_DIG0;
        8: b = CH_BSL;
        9: b = "\"";
        10: b = "/";
        default: do b = 8'($urandom_range(255)); while (b == CH_U || b == CH_X);
      endcase
      text_q.push_back(b);
    end else if (pick < 74) begin
      add_hex_escape(CH_X, 16'($urandom_range(255)), 2);
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0: val = 16'($urandom_range(16'h007F, 16'h0001));
        1: val = 16'($urandom_range(16'h07FF, 16'h0080));
        default: val = 16'($urandom_range(16'hFFFF, 16'h0800));
      endcase
      add_hex_escape(CH_U, val, 4);
    end else if (pick < 92) begin
      // An escaped zero mutes the rest of the string.
      kind = $urandom_range(1) ? CH_U : CH_X;
      add_hex_escape(kind, 16'h0000, (kind == CH_X) ? 2 : 4);
    end else if (is_final && $urandom_range(3) == 0) begin
      text_q.push_back(CH_BSL);
    end else begin
      kind = $urandom_range(1) ? CH_U : CH_X;
      add_hex_escape(kind, 16'($urandom), $urandom_range((kind == CH_X) ? 1 : 3, 0));
      // Unless the string ends here, a non-hex byte breaks the sequence.
      if (!is_final) begin
        do b = 8'($urandom_range(255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
        text_q.push_back(b);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!(sent >= 60 && sent < 110) && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int ntok;
    int base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Three-byte UTF-8 from mixed-case digits.
    text_q = '{CH_BSL, CH_U, "F", "f", "F", "f"};
    send_text();
    // Bad digit replays the sequence, then a lone backslash ends the string.
    text_q = '{CH_BSL, CH_U, "7", "G", CH_BSL};
    send_text();
    // Hex escape cut short by the end of the string.
    text_q = '{CH_BSL, CH_X, "4"};
    send_text();
    // Two-byte UTF-8 at the top of its range.
    text_q = '{CH_BSL, CH_U, "0", "7", "F", "F"};
    send_text();
    // Tab, a dropped escape, then a raw zero that mutes the final 0xFF.
    text_q = '{CH_BSL, CH_T, CH_BSL, CH_A, 8'h00, 8'hFF};
    send_text();
    drain();

    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      ntok = $urandom_range(8, 1);
      for (int t = 0; t < ntok; t++) add_token(t == ntok - 1);
      send_text();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("Decoded %0d strings (%0d raw bytes) into %0d checked results,",
             n_strings, n_raw, n_decoded);
    $display("covering every escape kind, broken hex, zero cutoff and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
sim/jsu_unescape_check.sv
sim/tb_top.sv
